// File: sv/block_average_bitcrusher_unit_defines.svh
// ----------------------------------------------------------------------------
// Block average bitcrusher assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_BITCRUSHER_UNIT_DEFINES_SVH
`define BLOCK_AVERAGE_BITCRUSHER_UNIT_DEFINES_SVH

// checked only outside reset
`define BAB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bab_pkg.sv
// ----------------------------------------------------------------------------
// Block average bitcrusher package
// Types, register codes and default constants shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bab_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int MAX_SHIFT_DEF   = 5;

   localparam int SHIFT_W  = 3;
   localparam int DEPTH_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_DEPTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE = 2'd2;

   localparam logic [SHIFT_W-1:0] FREQ_SHIFT_RST  = 3'd0;
   localparam logic [DEPTH_W-1:0] BIT_DEPTH_RST   = 5'd16;
   localparam logic               STEREO_MODE_RST = 1'b1;

   typedef struct packed {
      logic [SHIFT_W-1:0] freq_shift;
      logic [DEPTH_W-1:0] bit_depth;
      logic               stereo_mode;
   } cfg_type;

endpackage

`default_nettype wire

// File: sv/bab_accum.sv
// ----------------------------------------------------------------------------
// Block accumulator
// Takes requests, keeps even, odd and total sums and hands a finished block
// to the quantizers through a one-entry holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module bab_accum #(
   parameter int SAMPLE_BITS = bab_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_SHIFT   = bab_pkg::MAX_SHIFT_DEF
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         req_valid,
   output logic                                              req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]                req_sample_in,
   input  wire bab_pkg::cfg_type                             eff,
   input  wire logic                                         blk_take,
   output logic                                              blk_valid,
   output logic signed [SAMPLE_BITS+MAX_SHIFT:0]             blk_sum_a,
   output logic signed [SAMPLE_BITS+MAX_SHIFT:0]             blk_sum_b
);

   localparam int SUM_W = SAMPLE_BITS + MAX_SHIFT + 1;
   localparam int POS_W = MAX_SHIFT + 1;
   localparam int LEN_W = MAX_SHIFT + 2;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [SUM_W-1:0] even_ff, even_in, odd_ff, odd_in, total_ff, total_in;
   logic                    blk_valid_ff, blk_valid_in;
   logic signed [SUM_W-1:0] blk_a_ff, blk_a_in, blk_b_ff, blk_b_in;

   logic [LEN_W-1:0]        len;
   logic                    done;
   logic                    accept;
   logic signed [SUM_W-1:0] s_ext, even_add, odd_add, total_add, even_nxt, odd_nxt;

   always_comb begin
      len       = LEN_W'(2) << eff.freq_shift;
      done      = (LEN_W'(pos_ff) + LEN_W'(1)) >= len;
      req_stall = done && blk_valid_ff;
      accept    = req_valid && !req_stall;

      s_ext     = {{(SUM_W-SAMPLE_BITS){req_sample_in[SAMPLE_BITS-1]}}, req_sample_in};
      even_add  = even_ff + s_ext;
      odd_add   = odd_ff + s_ext;
      total_add = total_ff + s_ext;
      even_nxt  = pos_ff[0] ? even_ff : even_add;
      odd_nxt   = pos_ff[0] ? odd_add : odd_ff;

      pos_in   = pos_ff;
      even_in  = even_ff;
      odd_in   = odd_ff;
      total_in = total_ff;
      blk_a_in = blk_a_ff;
      blk_b_in = blk_b_ff;
      blk_valid_in = blk_valid_ff && !blk_take;

      if (accept) begin
         if (done) begin
            pos_in       = '0;
            even_in      = '0;
            odd_in       = '0;
            total_in     = '0;
            blk_valid_in = 1'b1;
            blk_a_in     = eff.stereo_mode ? even_nxt : total_add;
            blk_b_in     = odd_nxt;
         end else begin
            pos_in   = pos_ff + POS_W'(1);
            even_in  = even_nxt;
            odd_in   = odd_nxt;
            total_in = total_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         even_ff      <= '0;
         odd_ff       <= '0;
         total_ff     <= '0;
         blk_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         even_ff      <= even_in;
         odd_ff       <= odd_in;
         total_ff     <= total_in;
         blk_valid_ff <= blk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_a_ff <= blk_a_in;
      blk_b_ff <= blk_b_in;
   end

   assign blk_valid = blk_valid_ff;
   assign blk_sum_a = blk_a_ff;
   assign blk_sum_b = blk_b_ff;

endmodule

`default_nettype wire

// File: sv/bab_quant.sv
// ----------------------------------------------------------------------------
// Block quantizer
// Divides a block sum by its sample count and truncates toward zero to the
// quantization step.
// ----------------------------------------------------------------------------
`default_nettype none

module bab_quant #(
   parameter int SAMPLE_BITS = bab_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_SHIFT   = bab_pkg::MAX_SHIFT_DEF
) (
   input  wire logic signed [SAMPLE_BITS+MAX_SHIFT:0] sum,
   input  wire bab_pkg::cfg_type                     eff,
   output logic signed [SAMPLE_BITS-1:0]             avg
);

   localparam int SUM_W = SAMPLE_BITS + MAX_SHIFT + 1;

   logic [bab_pkg::SHIFT_W-1:0] lc;
   logic [bab_pkg::DEPTH_W-1:0] step_log;
   logic [5:0]                  k;
   logic [SUM_W-1:0]            bias;
   logic signed [SUM_W-1:0]     biased, scaled, kept;

   always_comb begin
      lc       = eff.stereo_mode ? eff.freq_shift
                                 : eff.freq_shift + bab_pkg::SHIFT_W'(1);
      step_log = bab_pkg::DEPTH_W'(SAMPLE_BITS - 1) - eff.bit_depth;
      k        = 6'(lc) + 6'(step_log);
      // round toward zero: bias negatives by divisor - 1
      bias     = sum[SUM_W-1] ? ~({SUM_W{1'b1}} << k) : '0;
      biased   = sum + $signed(bias);
      scaled   = biased >>> lc;
      kept     = scaled & $signed({SUM_W{1'b1}} << step_log);
      avg      = kept[SAMPLE_BITS-1:0];
   end

endmodule

`default_nettype wire

// File: sv/bab_burst.sv
// ----------------------------------------------------------------------------
// Result burst generator
// Holds the block's left and right values and plays them out as a run of
// held samples through the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bab_burst #(
   parameter int SAMPLE_BITS = bab_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_SHIFT   = bab_pkg::MAX_SHIFT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bab_pkg::cfg_type              eff,
   input  wire logic                          blk_valid,
   output logic                               blk_take,
   input  wire logic signed [SAMPLE_BITS-1:0] left_val,
   input  wire logic signed [SAMPLE_BITS-1:0] right_val,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                               rsp_last_of_run
);

   localparam int POS_W = MAX_SHIFT + 1;
   localparam int LEN_W = MAX_SHIFT + 2;

   logic                          act_ff, act_in;
   logic [POS_W-1:0]              idx_ff, idx_in, end_ff, end_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in, right_ff, right_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic             out_free, emit, at_end, load;
   logic [LEN_W-1:0] len;

   always_comb begin
      len      = LEN_W'(2) << eff.freq_shift;
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = act_ff && out_free;
      at_end   = idx_ff == end_ff;
      blk_take = !act_ff || (emit && at_end);
      load     = blk_valid && blk_take;

      act_in   = act_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      left_in  = left_ff;
      right_in = right_ff;
      priority if (load) begin
         act_in   = 1'b1;
         idx_in   = '0;
         end_in   = POS_W'(len - LEN_W'(1));
         left_in  = left_val;
         right_in = eff.stereo_mode ? right_val : left_val;
      end else if (emit) begin
         act_in = !at_end;
         idx_in = idx_ff + POS_W'(1);
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = idx_ff[0] ? right_ff : left_ff;
         rsp_last_in   = at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         idx_ff       <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         idx_ff       <= idx_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      right_ff      <= right_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/block_average_bitcrusher_unit.sv
// Results: a block passes the holding, burst value and response registers,
// then one per cycle while not stalled, for the 2 << block shift results.
// Throughput: one request per cycle; a block-ending request stalls only while
// the previous block is still held waiting for the burst generator.
// Reset: synchronous; clears position, sums and pending results and loads the
// register defaults.
// ----------------------------------------------------------------------------
// Block average bitcrusher unit
// Block averaging sample-rate reducer with bit-depth quantization.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_bitcrusher_unit #(
   parameter int SAMPLE_BITS = bab_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_SHIFT   = bab_pkg::MAX_SHIFT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]              rsp_sample_out,
   output logic                                       rsp_last_of_run,
   input  wire logic                                  csr_wr_en,
   input  wire logic [bab_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [bab_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SUM_W = SAMPLE_BITS + MAX_SHIFT + 1;

   bab_pkg::cfg_type cfg_ff, cfg_in, eff;

   logic                          blk_valid, blk_take;
   logic signed [SUM_W-1:0]       blk_sum_a, blk_sum_b;
   logic signed [SAMPLE_BITS-1:0] avg_a, avg_b;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bab_pkg::CSR_FREQ_SHIFT:  cfg_in.freq_shift  = csr_wdata[bab_pkg::SHIFT_W-1:0];
            bab_pkg::CSR_BIT_DEPTH:   cfg_in.bit_depth   = csr_wdata[bab_pkg::DEPTH_W-1:0];
            bab_pkg::CSR_STEREO_MODE: cfg_in.stereo_mode = csr_wdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_shift  <= bab_pkg::FREQ_SHIFT_RST;
         cfg_ff.bit_depth   <= bab_pkg::BIT_DEPTH_RST;
         cfg_ff.stereo_mode <= bab_pkg::STEREO_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // clamp to supported range
   always_comb begin
      eff = cfg_ff;
      if (cfg_ff.freq_shift > bab_pkg::SHIFT_W'(MAX_SHIFT)) begin
         eff.freq_shift = bab_pkg::SHIFT_W'(MAX_SHIFT);
      end
      if (cfg_ff.bit_depth > bab_pkg::DEPTH_W'(SAMPLE_BITS - 1)) begin
         eff.bit_depth = bab_pkg::DEPTH_W'(SAMPLE_BITS - 1);
      end
   end

   bab_accum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SHIFT   (MAX_SHIFT)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .eff           (eff),
      .blk_take      (blk_take),
      .blk_valid     (blk_valid),
      .blk_sum_a     (blk_sum_a),
      .blk_sum_b     (blk_sum_b)
   );

   bab_quant #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SHIFT   (MAX_SHIFT)
   ) u_quant_a (
      .sum (blk_sum_a),
      .eff (eff),
      .avg (avg_a)
   );

   bab_quant #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SHIFT   (MAX_SHIFT)
   ) u_quant_b (
      .sum (blk_sum_b),
      .eff (eff),
      .avg (avg_b)
   );

   bab_burst #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SHIFT   (MAX_SHIFT)
   ) u_burst (
      .clock           (clock),
      .reset           (reset),
      .eff             (eff),
      .blk_valid       (blk_valid),
      .blk_take        (blk_take),
      .left_val        (avg_a),
      .right_val       (avg_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// File: sv/bab_checker.sv
// ----------------------------------------------------------------------------
// Block average bitcrusher checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_average_bitcrusher_unit_defines.svh"

module bab_checker #(
   parameter int SAMPLE_BITS = bab_pkg::SAMPLE_BITS_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input wire logic                          rsp_last_of_run
);

   logic req_seen;

   assign req_seen = req_valid && !req_stall;

   `BAB_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid && !req_stall, "reset did not clear")
   `BAB_ASSERT(a_burst_contiguous, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid, "gap inside a run")
   `BAB_ASSERT(a_valid_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "response dropped while stalled")
   `BAB_ASSERT(a_payload_holds, clock, reset, rsp_valid && rsp_stall && !req_seen |=> $stable(rsp_sample_out) && $stable(rsp_last_of_run), "stalled payload changed")

endmodule

bind block_average_bitcrusher_unit bab_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_bab_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_sample_out  (rsp_sample_out),
   .rsp_last_of_run (rsp_last_of_run)
);

`default_nettype wire
